### rtl/core/ll1_predictive_parser_macros.svh
// Assertion macros shared by the parser checker.
`ifndef LL1_PREDICTIVE_PARSER_MACROS_SVH
`define LL1_PREDICTIVE_PARSER_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LL1PP_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ll1pp: implication check failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define LL1PP_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ll1pp: next-cycle check failed");

`endif

### rtl/core/ll1pp_pkg.sv
// Symbol codes, parse table and shared types of the LL(1) parser.
package ll1pp_pkg;

  localparam int unsigned StackDepthDefault = 32;
  localparam int unsigned QueueDepth        = 2;
  localparam int unsigned QueuePtrW         = $clog2(QueueDepth);
  localparam int unsigned QueueCntW         = $clog2(QueueDepth + 1);

  localparam logic [7:0] CharId   = 8'h61;  // 'a'
  localparam logic [7:0] CharPlus = 8'h2b;  // '+'
  localparam logic [7:0] CharStar = 8'h2a;  // '*'
  localparam logic [7:0] CharLpar = 8'h28;  // '('
  localparam logic [7:0] CharRpar = 8'h29;  // ')'

  typedef enum logic [3:0] {
    SymEnd  = 4'd0,
    SymId   = 4'd1,
    SymPlus = 4'd2,
    SymStar = 4'd3,
    SymLpar = 4'd4,
    SymRpar = 4'd5,
    SymE    = 4'd6,
    SymA    = 4'd7,
    SymT    = 4'd8,
    SymB    = 4'd9,
    SymF    = 4'd10,
    SymNone = 4'd15
  } sym_e;

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrSyntax   = 2'd1,
    ErrUnknown  = 2'd2,
    ErrOverflow = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    RuleETA    = 3'd0,
    RuleAPlus  = 3'd1,
    RuleAEps   = 3'd2,
    RuleTFB    = 3'd3,
    RuleBStar  = 3'd4,
    RuleBEps   = 3'd5,
    RuleFParen = 3'd6,
    RuleFId    = 3'd7
  } rule_e;

  typedef struct packed {
    logic  hit;
    rule_e rule;
  } lookup_t;

  // rhs0 is the leftmost symbol and ends up on top of the stack.
  typedef struct packed {
    logic [1:0] len;
    sym_e       rhs0;
    sym_e       rhs1;
    sym_e       rhs2;
  } prod_t;

  // Classified input item as it travels from front to back.
  typedef struct packed {
    logic eos;
    logic unknown;
    sym_e term;
  } item_t;

  function automatic sym_e char_to_sym(logic [7:0] c);
    sym_e s;
    unique case (c)
      CharId:   s = SymId;
      CharPlus: s = SymPlus;
      CharStar: s = SymStar;
      CharLpar: s = SymLpar;
      CharRpar: s = SymRpar;
      default:  s = SymNone;
    endcase
    return s;
  endfunction

  function automatic logic is_terminal(sym_e s);
    return (4'(s) < 4'(SymE));
  endfunction

  function automatic lookup_t lookup_rule(sym_e nt, sym_e t);
    lookup_t res;
    res.hit  = 1'b0;
    res.rule = RuleETA;
    unique case (nt)
      SymE: begin
        if (t == SymId || t == SymLpar) begin
          res.hit = 1'b1; res.rule = RuleETA;
        end
      end
      SymA: begin
        if (t == SymPlus) begin
          res.hit = 1'b1; res.rule = RuleAPlus;
        end else if (t == SymRpar || t == SymEnd) begin
          res.hit = 1'b1; res.rule = RuleAEps;
        end
      end
      SymT: begin
        if (t == SymId || t == SymLpar) begin
          res.hit = 1'b1; res.rule = RuleTFB;
        end
      end
      SymB: begin
        if (t == SymStar) begin
          res.hit = 1'b1; res.rule = RuleBStar;
        end else if (t == SymPlus || t == SymRpar || t == SymEnd) begin
          res.hit = 1'b1; res.rule = RuleBEps;
        end
      end
      SymF: begin
        if (t == SymLpar) begin
          res.hit = 1'b1; res.rule = RuleFParen;
        end else if (t == SymId) begin
          res.hit = 1'b1; res.rule = RuleFId;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic prod_t rule_prod(rule_e r);
    prod_t p;
    unique case (r)
      RuleETA:    p = '{len: 2'd2, rhs0: SymT,    rhs1: SymA,    rhs2: SymEnd};
      RuleAPlus:  p = '{len: 2'd3, rhs0: SymPlus, rhs1: SymT,    rhs2: SymA};
      RuleAEps:   p = '{len: 2'd0, rhs0: SymEnd,  rhs1: SymEnd,  rhs2: SymEnd};
      RuleTFB:    p = '{len: 2'd2, rhs0: SymF,    rhs1: SymB,    rhs2: SymEnd};
      RuleBStar:  p = '{len: 2'd3, rhs0: SymStar, rhs1: SymF,    rhs2: SymB};
      RuleBEps:   p = '{len: 2'd0, rhs0: SymEnd,  rhs1: SymEnd,  rhs2: SymEnd};
      RuleFParen: p = '{len: 2'd3, rhs0: SymLpar, rhs1: SymE,    rhs2: SymRpar};
      RuleFId:    p = '{len: 2'd1, rhs0: SymId,   rhs1: SymEnd,  rhs2: SymEnd};
      default:    p = '{len: 2'd0, rhs0: SymEnd,  rhs1: SymEnd,  rhs2: SymEnd};
    endcase
    return p;
  endfunction

endpackage

### rtl/core/ll1pp_front.sv
// Input side: takes characters and classifies them into terminal symbols.
module ll1pp_front import ll1pp_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] token_char_i,
  input  logic       end_of_sentence_i,
  input  logic       fifo_full_i,
  output logic       fifo_push_o,
  output item_t      fifo_item_o
);

  sym_e term;

  assign term        = char_to_sym(token_char_i);
  assign in_ready_o  = !fifo_full_i;
  assign fifo_push_o = in_valid_i && !fifo_full_i;

  // The terminator overrides whatever character rides along with it.
  always_comb begin
    fifo_item_o.eos     = end_of_sentence_i;
    fifo_item_o.unknown = !end_of_sentence_i && (term == SymNone);
    fifo_item_o.term    = end_of_sentence_i ? SymEnd : term;
  end

endmodule

### rtl/core/ll1pp_fifo.sv
// Short queue of classified items between the front and the stack engine.
module ll1pp_fifo import ll1pp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  empty_o,
  output item_t item_o
);

  item_t                slot_q [QueueDepth];
  logic [QueuePtrW-1:0] wptr_q, rptr_q;
  logic [QueueCntW-1:0] cnt_q;

  assign full_o  = (cnt_q == QueueCntW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign item_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QueuePtrW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QueuePtrW'(1);
      end
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + QueueCntW'(1);
        2'b01:   cnt_q <= cnt_q - QueueCntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### rtl/core/ll1pp_back.sv
// Stack engine: expands, pops and matches one stack step per cycle.
module ll1pp_back import ll1pp_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fifo_empty_i,
  input  item_t      fifo_item_i,
  output logic       fifo_pop_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       sentence_done_o,
  output logic       accepted_o,
  output logic [1:0] error_kind_o
);

  localparam int unsigned LevelW = $clog2(StackDepth + 1);
  localparam int unsigned AddrW  = $clog2(StackDepth);

  typedef enum logic [2:0] {
    StIdle,
    StExec,
    StPush2,
    StRefill,
    StPopMatch,
    StDone
  } state_e;

  state_e              state_q;
  sym_e                top_q;
  sym_e                term_q;
  logic                eos_q;
  rule_e               rule_q;
  logic [LevelW-1:0]   level_q;
  logic                err_q;
  err_e                err_kind_q;
  logic                out_valid_q;
  logic                done_q;
  logic                accepted_q;
  err_e                kind_q;

  // Entries below the top of stack; entry 0 stands for the end marker and is never
  // written, so a refill down to level 1 supplies the end marker directly.
  logic [3:0]          stack_mem [StackDepth];
  logic [3:0]          rd_q;

  lookup_t             lk;
  prod_t               prod_x;
  prod_t               prod_q;
  logic                top_term;
  logic                over;
  logic [LevelW-1:0]   level_m1;
  logic [LevelW-1:0]   level_m2;
  logic [AddrW-1:0]    wr_addr;
  logic [AddrW-1:0]    rd_addr;
  logic [3:0]          wr_data;
  logic                mem_we;

  assign lk       = lookup_rule(top_q, term_q);
  assign prod_x   = rule_prod(lk.rule);
  assign prod_q   = rule_prod(rule_q);
  assign top_term = is_terminal(top_q);
  assign over     = (({1'b0, level_q} + (LevelW + 1)'(prod_x.len))
                     > (LevelW + 1)'(StackDepth + 1));
  assign level_m1 = level_q - LevelW'(1);
  assign level_m2 = level_q - LevelW'(2);
  assign wr_addr  = level_m1[AddrW-1:0];
  assign rd_addr  = level_m2[AddrW-1:0];

  always_comb begin
    mem_we  = 1'b0;
    wr_data = 4'(prod_q.rhs1);
    if (state_q == StPush2) begin
      mem_we = 1'b1;
    end else if (state_q == StExec && level_q != '0 && !top_term && lk.hit && !over &&
                 prod_x.len >= 2'd2) begin
      mem_we  = 1'b1;
      wr_data = (prod_x.len == 2'd3) ? 4'(prod_x.rhs2) : 4'(prod_x.rhs1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      stack_mem[wr_addr] <= wr_data;
    end
    rd_q <= stack_mem[rd_addr];
  end

  assign fifo_pop_o      = (state_q == StIdle) && !fifo_empty_i;
  assign out_valid_o     = out_valid_q;
  assign sentence_done_o = done_q;
  assign accepted_o      = accepted_q;
  assign error_kind_o    = 2'(kind_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      top_q       <= SymE;
      term_q      <= SymEnd;
      eos_q       <= 1'b0;
      rule_q      <= RuleETA;
      level_q     <= LevelW'(2);
      err_q       <= 1'b0;
      err_kind_q  <= ErrNone;
      out_valid_q <= 1'b0;
      done_q      <= 1'b0;
      accepted_q  <= 1'b0;
      kind_q      <= ErrNone;
    end else begin
      // StDone refills the output register itself
      if (out_valid_q && out_ready_i && state_q != StDone) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StIdle: begin
          if (!fifo_empty_i) begin
            term_q <= fifo_item_i.term;
            eos_q  <= fifo_item_i.eos;
            if (err_q) begin
              state_q <= StDone;
            end else if (!fifo_item_i.eos && fifo_item_i.unknown) begin
              err_q      <= 1'b1;
              err_kind_q <= ErrUnknown;
              state_q    <= StDone;
            end else begin
              state_q <= StExec;
            end
          end
        end
        StExec: begin
          priority if (level_q == '0) begin
            err_q      <= 1'b1;
            err_kind_q <= ErrSyntax;
            state_q    <= StDone;
          end else if (top_term) begin
            if (top_q != term_q) begin
              err_q      <= 1'b1;
              err_kind_q <= ErrSyntax;
              state_q    <= StDone;
            end else if (term_q == SymEnd) begin
              state_q <= StDone;
            end else begin
              // pop the matched terminal, fetch the entry below
              level_q <= level_m1;
              state_q <= StPopMatch;
            end
          end else if (!lk.hit) begin
            err_q      <= 1'b1;
            err_kind_q <= ErrSyntax;
            state_q    <= StDone;
          end else if (over) begin
            err_q      <= 1'b1;
            err_kind_q <= ErrOverflow;
            state_q    <= StDone;
          end else begin
            unique case (prod_x.len)
              2'd0: begin
                level_q <= level_m1;
                state_q <= StRefill;
              end
              2'd1: begin
                top_q <= prod_x.rhs0;
              end
              2'd2: begin
                top_q   <= prod_x.rhs0;
                level_q <= level_q + LevelW'(1);
              end
              default: begin
                // rightmost symbol written now, middle one next cycle
                rule_q  <= lk.rule;
                level_q <= level_q + LevelW'(1);
                state_q <= StPush2;
              end
            endcase
          end
        end
        StPush2: begin
          top_q   <= prod_q.rhs0;
          level_q <= level_q + LevelW'(1);
          state_q <= StExec;
        end
        StRefill: begin
          top_q   <= (level_q == LevelW'(1)) ? SymEnd : sym_e'(rd_q);
          state_q <= StExec;
        end
        StPopMatch: begin
          // terminal consumed: refill the top and finish the item
          top_q   <= (level_q == LevelW'(1)) ? SymEnd : sym_e'(rd_q);
          state_q <= StDone;
        end
        StDone: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            done_q      <= eos_q;
            accepted_q  <= eos_q && !err_q;
            kind_q      <= (eos_q && err_q) ? err_kind_q : ErrNone;
            if (eos_q) begin
              top_q      <= SymE;
              level_q    <= LevelW'(2);
              err_q      <= 1'b0;
              err_kind_q <= ErrNone;
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

### rtl/core/ll1_predictive_parser.sv
// LL(1) expression recognizer: E->TA, A->+TA|e, T->FB, B->*FB|e, F->(E)|a.
// From the input transfer: the item is taken from the queue, then one stack step a cycle
// (an expansion, a three-symbol rule with a second push, an epsilon pop with a refill, a match
// with a pop and a refill, or the end marker), then the result; an ignored or unknown one skips them.
// One item in the stack engine at a time: the next is taken from the queue only back in idle.
// Reset: stack holds end marker below E, level 2, error cleared; no clearing pass.
module ll1_predictive_parser import ll1pp_pkg::*; #(
  parameter int unsigned StackDepth = StackDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] token_char_i,
  input  logic       end_of_sentence_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       sentence_done_o,
  output logic       accepted_o,
  output logic [1:0] error_kind_o
);

  logic  fifo_push, fifo_pop, fifo_full, fifo_empty;
  item_t push_item, pop_item;

  ll1pp_front u_front (
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .token_char_i     (token_char_i),
    .end_of_sentence_i(end_of_sentence_i),
    .fifo_full_i      (fifo_full),
    .fifo_push_o      (fifo_push),
    .fifo_item_o      (push_item)
  );

  ll1pp_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (fifo_push),
    .item_i (push_item),
    .full_o (fifo_full),
    .pop_i  (fifo_pop),
    .empty_o(fifo_empty),
    .item_o (pop_item)
  );

  ll1pp_back #(
    .StackDepth(StackDepth)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_empty_i   (fifo_empty),
    .fifo_item_i    (pop_item),
    .fifo_pop_o     (fifo_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .sentence_done_o(sentence_done_o),
    .accepted_o     (accepted_o),
    .error_kind_o   (error_kind_o)
  );

endmodule

### rtl/core/ll1pp_checker.sv
// Port-level checks on the parser's result channel, bound to the top level.
`include "ll1_predictive_parser_macros.svh"

module ll1pp_checker import ll1pp_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       sentence_done_o,
  input logic       accepted_o,
  input logic [1:0] error_kind_o
);

  `LL1PP_ASSERT_NXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o)
  `LL1PP_ASSERT_NXT(a_out_stable, out_valid_o && !out_ready_i,
    $stable(sentence_done_o) && $stable(accepted_o) && $stable(error_kind_o))
  `LL1PP_ASSERT_IMP(a_accept_clean, out_valid_o && accepted_o,
    sentence_done_o && error_kind_o == 2'(ErrNone))
  `LL1PP_ASSERT_IMP(a_mid_quiet, out_valid_o && !sentence_done_o,
    !accepted_o && error_kind_o == 2'(ErrNone))
  `LL1PP_ASSERT_IMP(a_reject_kind, out_valid_o && sentence_done_o && !accepted_o,
    error_kind_o != 2'(ErrNone))

endmodule

bind ll1_predictive_parser ll1pp_checker u_ll1pp_checker (.*);
